>>> sv/bba_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// bitmap block allocator. No dependencies.
package bba_pkg;

	// Sizes.
	localparam int DEF_MAX_BLOCKS = 1024;
	localparam int WORD_BITS      = 64;
	localparam int WORD_LSB       = 6;

	// Field and register widths.
	localparam int KIND_W     = 2;
	localparam int TGT_W      = 10;
	localparam int ENT_W      = 8;
	localparam int STAT_W     = 2;
	localparam int OFF_W      = 42;
	localparam int LIVE_W     = 11;
	localparam int BSIZE_W    = 32;
	localparam int BCNT_W     = 11;
	localparam int CAP_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_INSPECT = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DOUBLE    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd2;

	// Register reset values.
	localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE  = 32'd4096;
	localparam logic [BCNT_W-1:0]  RST_BLOCK_COUNT = 11'd1024;
	localparam logic [CAP_W-1:0]   DEF_CAPACITY    = 8'd8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic scan_init;
		logic scan_step;
		logic grant;
		logic answer;
		logic lookup;
		logic decide;
		logic reply_range;
		logic reply_exhaust;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic restart;
		logic clear_done;
		logic is_acquire;
		logic out_of_range;
		logic found;
		logic exhausted;
	} sts_t;

endpackage

>>> sv/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bba_ctrl.sv
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg for the command and status types.
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_ROUTE  = 7'b0000100,
		ST_SCAN   = 7'b0001000,
		ST_GRANT  = 7'b0010000,
		ST_ANSWER = 7'b0100000,
		ST_DECIDE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_ROUTE;
				end
			end
			ST_ROUTE: begin
				if (sts.is_acquire) begin
					cmd.scan_init = 1'b1;
					state_nxt     = ST_SCAN;
				end else if (sts.out_of_range) begin
					cmd.reply_range = 1'b1;
					state_nxt       = ST_IDLE;
				end else begin
					cmd.lookup = 1'b1;
					state_nxt  = ST_DECIDE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.found) begin
					state_nxt = ST_GRANT;
				end else if (sts.exhausted) begin
					cmd.reply_exhaust = 1'b1;
					state_nxt         = ST_IDLE;
				end
			end
			ST_GRANT: begin
				cmd.grant = 1'b1;
				state_nxt = ST_ANSWER;
			end
			ST_ANSWER: begin
				cmd.answer = 1'b1;
				state_nxt  = ST_IDLE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		// A new block count wipes all allocation state.
		if (sts.restart) begin
			state_nxt = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> sv/bba_dp.sv
// Datapath of the bitmap block allocator: registers, bitmap and metadata
// memories, word scan, offset multiplier and result registers.
// Depends on bba_pkg and bba_ram.
module bba_dp #(
	parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bba_pkg::cmd_t                    cmd,
	output bba_pkg::sts_t                    sts,
	input  logic                             cfg_wr_en,
	input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [bba_pkg::KIND_W-1:0]       kind,
	input  logic [bba_pkg::TGT_W-1:0]        target_block,
	input  logic [bba_pkg::ENT_W-1:0]        frontier_entries,
	output logic                             done,
	output logic [bba_pkg::STAT_W-1:0]       status,
	output logic [bba_pkg::TGT_W-1:0]        granted_block,
	output logic [bba_pkg::OFF_W-1:0]        byte_offset,
	output logic [bba_pkg::ENT_W-1:0]        prior_entries,
	output logic                             tainted,
	output logic [bba_pkg::LIVE_W-1:0]       live_blocks
);

	localparam int WB     = bba_pkg::WORD_BITS;
	localparam int WORDS  = MAX_BLOCKS / bba_pkg::WORD_BITS;
	localparam int BIDX_W = $clog2(MAX_BLOCKS);
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int PROD_W = BIDX_W + bba_pkg::BSIZE_W;
	localparam int META_W = bba_pkg::ENT_W + 1;
	localparam int LSB    = bba_pkg::WORD_LSB;
	localparam int CMP_W  = CNT_W + bba_pkg::TGT_W;
	// Reset block count, held to the number of blocks the memories provide.
	localparam int RST_CNT = (int'(bba_pkg::RST_BLOCK_COUNT) > MAX_BLOCKS)
	                         ? MAX_BLOCKS : int'(bba_pkg::RST_BLOCK_COUNT);

	// Configuration.
	logic [bba_pkg::BSIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]            blk_cnt_q;
	logic [bba_pkg::CAP_W-1:0]   capacity_q;

	// Request and allocation state.
	logic [bba_pkg::KIND_W-1:0]  kind_q;
	logic [bba_pkg::TGT_W-1:0]   target_q;
	logic [bba_pkg::ENT_W-1:0]   entries_q;
	logic [BIDX_W-1:0]           clr_q;
	logic [WIDX_W-1:0]           hint_q;
	logic [CNT_W-1:0]            live_q;

	// Scan state.
	logic [WIDX_W-1:0]           rd_idx_q;
	logic [WIDX_W-1:0]           chk_idx_q;
	logic                        chk_valid_q;
	logic [CNT_W-1:0]            chk_pass_q;
	logic [BIDX_W-1:0]           blk_q;
	logic [WIDX_W-1:0]           grant_word_q;
	logic [WB-1:0]               new_word_q;
	logic [PROD_W-1:0]           prod_q;

	// Result registers.
	logic                        done_q;
	logic [bba_pkg::STAT_W-1:0]  status_q;
	logic [bba_pkg::TGT_W-1:0]   granted_q;
	logic [bba_pkg::OFF_W-1:0]   offset_q;
	logic [bba_pkg::ENT_W-1:0]   prior_q;
	logic                        tainted_q;
	logic [bba_pkg::LIVE_W-1:0]  live_out_q;

	// Memory ports.
	logic                        bm_we;
	logic [WIDX_W-1:0]           bm_waddr;
	logic [WB-1:0]               bm_wdata;
	logic [WIDX_W-1:0]           bm_raddr;
	logic [WB-1:0]               bm_rdata;
	logic                        meta_we;
	logic [BIDX_W-1:0]           meta_waddr;
	logic [META_W-1:0]           meta_wdata;
	logic [BIDX_W-1:0]           meta_raddr;
	logic [META_W-1:0]           meta_rdata;

	// Combinational helpers.
	logic                        restart;
	logic [CNT_W-1:0]            words;
	logic [LSB-1:0]              rem;
	logic [WIDX_W-1:0]           hint_start;
	logic [WIDX_W-1:0]           rd_next;
	logic [BIDX_W-1:0]           tgt_idx;
	logic [WIDX_W-1:0]           tgt_word;
	logic [LSB-1:0]              tgt_bit;
	logic [WB-1:0]               tgt_mask;
	logic                        tgt_busy;
	logic                        is_inspect;
	logic                        free_ok;
	logic [WB-1:0]               free_vec;
	logic [WB-1:0]               low_free;
	logic [LSB-1:0]              enc;
	logic                        word_full;
	logic [WIDX_W-1:0]           clr_word;
	logic [WB-1:0]               clr_init;
	logic [bba_pkg::BCNT_W-1:0]  bc_raw;
	logic [CNT_W-1:0]            bc_clamped;
	logic [bba_pkg::CAP_W-1:0]   cap_raw;
	logic [BIDX_W-1:0]           mul_a;
	logic                        reply;
	logic [bba_pkg::STAT_W-1:0]  res_status;
	logic [bba_pkg::TGT_W-1:0]   res_granted;
	logic [bba_pkg::OFF_W-1:0]   res_offset;
	logic [bba_pkg::ENT_W-1:0]   res_prior;
	logic                        res_tainted;
	logic [bba_pkg::LIVE_W-1:0]  res_live;

	bba_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_bitmap (
		.clk     (clk),
		.wr_en   (bm_we),
		.wr_addr (bm_waddr),
		.wr_data (bm_wdata),
		.rd_addr (bm_raddr),
		.rd_data (bm_rdata)
	);

	bba_ram #(.WIDTH(META_W), .DEPTH(MAX_BLOCKS)) u_meta (
		.clk     (clk),
		.wr_en   (meta_we),
		.wr_addr (meta_waddr),
		.wr_data (meta_wdata),
		.rd_addr (meta_raddr),
		.rd_data (meta_rdata)
	);

	assign restart  = cfg_wr_en && (cfg_index == bba_pkg::REG_BLOCK_COUNT);
	assign words    = (blk_cnt_q + CNT_W'(WB - 1)) >> LSB;
	assign rem      = blk_cnt_q[LSB-1:0];
	assign hint_start = (CNT_W'(hint_q) < words) ? hint_q : '0;
	assign rd_next  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == words) ? '0
	                                                            : rd_idx_q + WIDX_W'(1);

	assign tgt_idx    = BIDX_W'(target_q);
	assign tgt_word   = WIDX_W'(tgt_idx >> LSB);
	assign tgt_bit    = target_q[LSB-1:0];
	assign tgt_mask   = WB'(1) << tgt_bit;
	assign tgt_busy   = bm_rdata[tgt_bit];
	assign is_inspect = (kind_q == bba_pkg::KIND_INSPECT);
	assign free_ok    = cmd.decide && !is_inspect && tgt_busy;

	// Lowest clear bit of the word under test, isolated and encoded.
	assign free_vec  = ~bm_rdata;
	assign low_free  = free_vec & (~free_vec + WB'(1));
	assign word_full = (free_vec == '0);

	always_comb begin
		enc = '0;
		for (int j = 0; j < WB; j++) begin
			if (low_free[j]) begin
				enc = enc | LSB'(j);
			end
		end
	end

	// Bits above the block count in the last word stay set.
	assign clr_word = WIDX_W'(clr_q);
	assign clr_init = ((clr_word == WIDX_W'(words - CNT_W'(1))) && (rem != '0))
	                  ? ~((WB'(1) << rem) - WB'(1)) : '0;

	assign bc_raw     = cfg_data[bba_pkg::BCNT_W-1:0];
	assign bc_clamped = (bc_raw == '0) ? CNT_W'(1)
	                  : (32'(bc_raw) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
	                  : CNT_W'(bc_raw);
	assign cap_raw    = cfg_data[bba_pkg::CAP_W-1:0];

	assign sts.restart      = restart;
	assign sts.clear_done   = (clr_q == BIDX_W'(MAX_BLOCKS - 1));
	assign sts.is_acquire   = (kind_q == bba_pkg::KIND_ACQUIRE);
	assign sts.out_of_range = (CMP_W'(target_q) >= CMP_W'(blk_cnt_q));
	assign sts.found        = chk_valid_q && !word_full;
	assign sts.exhausted    = chk_valid_q && word_full &&
	                          ((chk_pass_q + CNT_W'(1)) == words);

	// Memory port selection.
	always_comb begin
		bm_we      = 1'b0;
		bm_waddr   = tgt_word;
		bm_wdata   = bm_rdata & ~tgt_mask;
		meta_we    = 1'b0;
		meta_waddr = tgt_idx;
		meta_wdata = (entries_q <= capacity_q) ? {1'b0, entries_q}
		                                       : {1'b1, bba_pkg::ENT_W'(0)};
		if (cmd.clear_step) begin
			bm_we      = (32'(clr_q) < 32'(WORDS));
			bm_waddr   = clr_word;
			bm_wdata   = clr_init;
			meta_we    = 1'b1;
			meta_waddr = clr_q;
			meta_wdata = '0;
		end else if (cmd.grant) begin
			bm_we    = 1'b1;
			bm_waddr = grant_word_q;
			bm_wdata = new_word_q;
		end else if (free_ok) begin
			bm_we   = 1'b1;
			meta_we = (kind_q == bba_pkg::KIND_RELEASE);
		end
	end

	assign bm_raddr   = cmd.scan_step ? rd_idx_q : tgt_word;
	assign meta_raddr = cmd.grant ? blk_q : tgt_idx;
	assign mul_a      = cmd.grant ? blk_q : tgt_idx;

	// Result selection.
	assign reply = cmd.reply_range || cmd.reply_exhaust || cmd.answer || cmd.decide;

	always_comb begin
		res_status  = bba_pkg::STAT_OK;
		res_granted = '0;
		res_offset  = '0;
		res_prior   = '0;
		res_tainted = 1'b0;
		res_live    = bba_pkg::LIVE_W'(live_q);
		if (cmd.reply_range) begin
			res_status = bba_pkg::STAT_RANGE;
		end else if (cmd.reply_exhaust) begin
			res_status = bba_pkg::STAT_EXHAUSTED;
		end else if (cmd.answer || (cmd.decide && is_inspect)) begin
			res_granted = cmd.answer ? bba_pkg::TGT_W'(blk_q) : target_q;
			res_offset  = bba_pkg::OFF_W'(prod_q);
			res_prior   = meta_rdata[bba_pkg::ENT_W-1:0];
			res_tainted = meta_rdata[bba_pkg::ENT_W];
		end else if (free_ok) begin
			res_live = bba_pkg::LIVE_W'(live_q - CNT_W'(1));
		end else begin
			res_status = bba_pkg::STAT_DOUBLE;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= bba_pkg::RST_BLOCK_SIZE;
			blk_cnt_q     <= CNT_W'(RST_CNT);
			capacity_q    <= bba_pkg::DEF_CAPACITY;
			clr_q         <= '0;
			hint_q        <= '0;
			live_q        <= '0;
			chk_valid_q   <= 1'b0;
			chk_pass_q    <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= reply;
			if (cfg_wr_en) begin
				case (cfg_index)
					bba_pkg::REG_BLOCK_SIZE:  block_size_q  <= cfg_data;
					bba_pkg::REG_BLOCK_COUNT: blk_cnt_q     <= bc_clamped;
					bba_pkg::REG_CAPACITY: begin
						capacity_q <= (cap_raw == '0) ? bba_pkg::DEF_CAPACITY : cap_raw;
					end
					default: ;
				endcase
			end
			if (restart) begin
				clr_q  <= '0;
				hint_q <= '0;
				live_q <= '0;
			end else begin
				if (cmd.clear_step) begin
					clr_q <= clr_q + BIDX_W'(1);
				end
				if (cmd.grant) begin
					hint_q <= grant_word_q;
					live_q <= live_q + CNT_W'(1);
				end else if (free_ok) begin
					live_q <= live_q - CNT_W'(1);
				end
			end
			if (cmd.scan_init) begin
				chk_valid_q <= 1'b0;
				chk_pass_q  <= '0;
			end else if (cmd.scan_step) begin
				chk_valid_q <= 1'b1;
				if (chk_valid_q) begin
					chk_pass_q <= chk_pass_q + CNT_W'(1);
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= kind;
			target_q  <= target_block;
			entries_q <= frontier_entries;
		end
		if (cmd.scan_init) begin
			rd_idx_q <= hint_start;
		end else if (cmd.scan_step) begin
			rd_idx_q  <= rd_next;
			chk_idx_q <= rd_idx_q;
			if (sts.found) begin
				blk_q        <= BIDX_W'({chk_idx_q, enc});
				grant_word_q <= chk_idx_q;
				new_word_q   <= bm_rdata | low_free;
			end
		end
		if (cmd.lookup || cmd.grant) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(block_size_q);
		end
		if (reply) begin
			status_q   <= res_status;
			granted_q  <= res_granted;
			offset_q   <= res_offset;
			prior_q    <= res_prior;
			tainted_q  <= res_tainted;
			live_out_q <= res_live;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign granted_block = granted_q;
	assign byte_offset   = offset_q;
	assign prior_entries = prior_q;
	assign tainted       = tainted_q;
	assign live_blocks   = live_out_q;

endmodule

>>> sv/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp (which uses bba_ram).
//
// Channel   Direction  Handshake                Payload
// request   in         start & !busy            kind, target_block, frontier_entries
// result    out        done, one cycle          status, granted_block, byte_offset,
//                                               prior_entries, tainted, live_blocks
// config    in         cfg_wr_en                cfg_index, cfg_data
//
// Sequencing: a request is taken when start is high and busy is low. Release,
// restore and inspect answer after route and decide steps (an index out of
// range straight from route). An acquire scans from the roving hint, examines
// at most words words, with words equal to ceil(blocks in use/64), and grants
// the lowest free block of the first word not full, or answers exhausted.
// The bitmap memory is read one word per cycle during the scan.
// Reset and every write of the block count register start a clearing pass
// over both memories, during which busy is high; other registers may be
// written at any time while idle. Results cannot be stalled: done marks each
// one for exactly one cycle and busy drops in that same cycle.
module bitmap_block_allocator_top #(
	// Must be a multiple of 64.
	parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel.
	input  logic                             start,
	output logic                             busy,
	input  logic [bba_pkg::KIND_W-1:0]       kind,
	input  logic [bba_pkg::TGT_W-1:0]        target_block,
	input  logic [bba_pkg::ENT_W-1:0]        frontier_entries,
	// Result channel.
	output logic                             done,
	output logic [bba_pkg::STAT_W-1:0]       status,
	output logic [bba_pkg::TGT_W-1:0]        granted_block,
	output logic [bba_pkg::OFF_W-1:0]        byte_offset,
	output logic [bba_pkg::ENT_W-1:0]        prior_entries,
	output logic                             tainted,
	output logic [bba_pkg::LIVE_W-1:0]       live_blocks,
	// Configuration write port.
	input  logic                             cfg_wr_en,
	input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// The controller sequences each request through route and then scan, grant
	// and answer steps or a decide step; the datapath owns every register and
	// memory and reports back the few conditions that steer the sequence.
	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// The datapath holds the busy bitmap as 64-bit words in one memory and
	// the per-block frontier count and taint mark in another. An acquire
	// reads one word per cycle from the roving hint, wrapping at the last
	// word in use, and takes the lowest clear bit of the first word that is
	// not full. The byte offset comes from a single registered multiplier.
	bba_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.kind             (kind),
		.target_block     (target_block),
		.frontier_entries (frontier_entries),
		.done             (done),
		.status           (status),
		.granted_block    (granted_block),
		.byte_offset      (byte_offset),
		.prior_entries    (prior_entries),
		.tainted          (tainted),
		.live_blocks      (live_blocks)
	);

endmodule
